/* rtl/core/chg_pkg.sv */
// ----------------------------------------------------------------------------
// chg_pkg
// Types and constants shared by the charger start gate and current ramp.
// ----------------------------------------------------------------------------
package chg_pkg;

    // Item kinds
    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_TICK  = 2'd1,
        OP_DUTY  = 2'd2,
        OP_NONE  = 2'd3
    } chg_op_t;

    // Interface modes; codes 5 to 7 keep the start decision
    typedef enum logic [2:0] {
        MODE_NONE  = 3'd0,
        MODE_DC    = 3'd1,
        MODE_LIM   = 3'd2,
        MODE_CPC   = 3'd3,
        MODE_COMBO = 3'd4,
        MODE_OTHER = 3'd5,
        MODE_RSV6  = 3'd6,
        MODE_RSV7  = 3'd7
    } chg_mode_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_INTERFACE_MODE = 2'd0,
        REG_VOLTAGE_TARGET = 2'd1,
        REG_TIMEOUT_RELOAD = 2'd2,
        REG_MAX_CURRENT    = 2'd3
    } chg_reg_t;

    localparam int unsigned CFG_DATA_W        = 10;
    localparam logic [9:0]  TIMEOUT_RESET     = 10'd300;
    localparam logic [7:0]  MAX_CURRENT_RESET = 8'h78;
    localparam logic [13:0] VOLT_SCALE        = 14'd10;

    typedef struct packed {
        chg_mode_t  interface_mode;
        logic [9:0] voltage_target;
        logic [9:0] timeout_reload;
        logic [7:0] max_current;
    } chg_cfg_t;

    typedef struct packed {
        chg_op_t    opcode;
        logic       run_request;
        logic       ac_request;
        logic       charge_mode_active;
        logic [9:0] measured_volts;
        logic [7:0] pilot_duty;
    } chg_item_t;

    typedef struct packed {
        logic        clear_to_start;
        logic        pull_in_evse;
        logic        frame_valid;
        logic [15:0] setpoint_word;
        logic [7:0]  current_setpoint;
        logic        charging;
        logic        pilot_timeout;
    } chg_result_t;

endpackage

/* rtl/core/chg_cfg_regs.sv */
// ----------------------------------------------------------------------------
// chg_cfg_regs
// Configuration register file written over the config write channel.
// ----------------------------------------------------------------------------
module chg_cfg_regs
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        wr_en,
    input  chg_pkg::chg_reg_t           wr_index,
    input  logic [chg_pkg::CFG_DATA_W-1:0] wr_data,
    output chg_pkg::chg_cfg_t           cfg
);
    import chg_pkg::*;

    chg_cfg_t cfg_reg;
    chg_cfg_t cfg_next;

    // Select the register addressed by the write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                REG_INTERFACE_MODE: cfg_next.interface_mode = chg_mode_t'(wr_data[2:0]);
                REG_VOLTAGE_TARGET: cfg_next.voltage_target = wr_data[9:0];
                REG_TIMEOUT_RELOAD: cfg_next.timeout_reload = wr_data[9:0];
                REG_MAX_CURRENT:    cfg_next.max_current    = wr_data[7:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold the registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.interface_mode <= MODE_NONE;
            cfg_reg.voltage_target <= '0;
            cfg_reg.timeout_reload <= TIMEOUT_RESET;
            cfg_reg.max_current    <= MAX_CURRENT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/core/chg_step.sv */
// ----------------------------------------------------------------------------
// chg_step
// Gate and ramp state with the single-pass update for one item.
// ----------------------------------------------------------------------------
module chg_step
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step_en,
    input  chg_pkg::chg_item_t   item,
    input  chg_pkg::chg_cfg_t    cfg,
    output chg_pkg::chg_result_t result
);
    import chg_pkg::*;

    logic [7:0] stored_duty_reg,   stored_duty_next;
    logic [9:0] timeout_count_reg, timeout_count_next;
    logic       timed_out_reg,     timed_out_next;
    logic       start_permit_reg,  start_permit_next;
    logic [7:0] current_ramp_reg,  current_ramp_next;
    logic       charging_reg,      charging_next;

    logic [13:0] volt_word;
    logic [8:0]  ramp_step;

    // Scale the voltage target to the frame word
    assign volt_word = {4'd0, cfg.voltage_target} * VOLT_SCALE;

    // Step the ramp toward the target, clamp to the maximum
    always_comb
    begin
        ramp_step = {1'b0, current_ramp_reg};
        if (item.measured_volts < cfg.voltage_target)
        begin
            ramp_step = ramp_step + 9'd1;
        end
        else if (current_ramp_reg != 8'd0)
        begin
            ramp_step = ramp_step - 9'd1;
        end
        if (ramp_step >= {1'b0, cfg.max_current})
        begin
            ramp_step = {1'b0, cfg.max_current};
        end
    end

    // Work out the next state and the result for this item
    always_comb
    begin
        stored_duty_next   = stored_duty_reg;
        timeout_count_next = timeout_count_reg;
        timed_out_next     = timed_out_reg;
        start_permit_next  = start_permit_reg;
        current_ramp_next  = current_ramp_reg;
        charging_next      = charging_reg;
        result             = '0;

        case (item.opcode)
            OP_START:
            begin
                case (cfg.interface_mode)
                    MODE_NONE:
                    begin
                        if (item.run_request && item.ac_request)
                        begin
                            start_permit_next = !timed_out_reg;
                        end
                        else
                        begin
                            timed_out_next     = 1'b0;
                            timeout_count_next = cfg.timeout_reload;
                            start_permit_next  = 1'b0;
                        end
                    end
                    MODE_DC:
                    begin
                        start_permit_next = (stored_duty_reg != 8'd0) && item.run_request;
                    end
                    MODE_LIM, MODE_CPC, MODE_COMBO:
                    begin
                        start_permit_next = item.run_request && item.ac_request;
                    end
                    default:
                    begin
                        start_permit_next = start_permit_reg;
                    end
                endcase
            end
            OP_TICK:
            begin
                if (item.charge_mode_active)
                begin
                    // Pilot duty countdown
                    if (stored_duty_reg == 8'd0)
                    begin
                        if (timeout_count_reg != 10'd0)
                        begin
                            timeout_count_next = timeout_count_reg - 10'd1;
                        end
                        else
                        begin
                            timed_out_next = 1'b1;
                        end
                    end
                    else
                    begin
                        timeout_count_next = cfg.timeout_reload;
                        timed_out_next     = 1'b0;
                    end
                    result.pull_in_evse     = start_permit_reg;
                    result.frame_valid      = 1'b1;
                    result.setpoint_word    = {2'd0, volt_word};
                    result.current_setpoint = current_ramp_reg;
                    if (start_permit_reg)
                    begin
                        current_ramp_next = ramp_step[7:0];
                        charging_next     = 1'b1;
                    end
                    else
                    begin
                        current_ramp_next = 8'd0;
                    end
                end
                else
                begin
                    charging_next = 1'b0;
                end
            end
            OP_DUTY:
            begin
                stored_duty_next = item.pilot_duty;
            end
            default:
            begin
                stored_duty_next = stored_duty_reg;
            end
        endcase

        result.clear_to_start = start_permit_next;
        result.charging       = charging_next;
        result.pilot_timeout  = timed_out_next;
    end

    // Commit the state when the item passes through
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stored_duty_reg   <= '0;
            timeout_count_reg <= TIMEOUT_RESET;
            timed_out_reg     <= 1'b0;
            start_permit_reg  <= 1'b0;
            current_ramp_reg  <= '0;
            charging_reg      <= 1'b0;
        end
        else if (step_en)
        begin
            stored_duty_reg   <= stored_duty_next;
            timeout_count_reg <= timeout_count_next;
            timed_out_reg     <= timed_out_next;
            start_permit_reg  <= start_permit_next;
            current_ramp_reg  <= current_ramp_next;
            charging_reg      <= charging_next;
        end
    end

endmodule

/* rtl/core/charger_start_gate_and_current_ramp.sv */
// ----------------------------------------------------------------------------
// charger_start_gate_and_current_ramp
// Charger start gate with pilot timeout and current setpoint ramp.
// ----------------------------------------------------------------------------
//  channel   direction  signals                          accepted when
//  s_axis    in         s_tvalid s_tready s_tdata s_tuser  s_tvalid & s_tready
//  m_axis    out        m_tvalid m_tready m_tdata m_tuser  m_tvalid & m_tready
//  cfg       in         cfg_valid cfg_ready cfg_index cfg_data  cfg_valid & cfg_ready
//
// One item per cycle while m_tready does not stall: an item is held in the input
// register, the state update and result are formed in one pass and land in the
// result register. A stall on m_tready holds the result register and
// then the input register; s_tready drops only when both are full. Reset
// clears the state and loads the register reset values; no clearing pass.
// ----------------------------------------------------------------------------
module charger_start_gate_and_current_ramp
(
    input  logic        clk,
    input  logic        rst_n,
    // input item
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // run_request, ac_request, charge_mode_active,
                                   // measured_volts[9:0], pilot_duty[7:0], zero pad
    input  logic [1:0]  s_tuser,   // opcode[1:0]
    // result item
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // clear_to_start, pull_in_evse, setpoint_word[15:0],
                                   // current_setpoint[7:0], charging, pilot_timeout, zero pad
    output logic        m_tuser,   // frame_valid
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [9:0]  cfg_data
);
    import chg_pkg::*;

    logic        in_valid_reg,  in_valid_next;
    chg_item_t   in_item_reg;
    logic        out_valid_reg, out_valid_next;
    chg_result_t out_res_reg;
    logic        advance;
    logic        s_accept;
    chg_item_t   s_item;
    chg_cfg_t    cfg;
    chg_result_t step_res;

    // Unpack the input item
    assign s_item.opcode             = chg_op_t'(s_tuser);
    assign s_item.run_request        = s_tdata[0];
    assign s_item.ac_request         = s_tdata[1];
    assign s_item.charge_mode_active = s_tdata[2];
    assign s_item.measured_volts     = s_tdata[12:3];
    assign s_item.pilot_duty         = s_tdata[20:13];

    // Handshake control
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the item and the result
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_item_reg <= s_item;
        end
        if (advance)
        begin
            out_res_reg <= step_res;
        end
    end

    chg_cfg_regs u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (chg_reg_t'(cfg_index)),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    chg_step u_step
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .result  (step_res)
    );

    // Pack the result item
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.frame_valid;
    assign m_tdata  = {4'd0,
                       out_res_reg.pilot_timeout,
                       out_res_reg.charging,
                       out_res_reg.current_setpoint,
                       out_res_reg.setpoint_word,
                       out_res_reg.pull_in_evse,
                       out_res_reg.clear_to_start};

endmodule

/* test/chg_checker.sv */
// ----------------------------------------------------------------------------
// chg_checker
// Watches the item, result and register channels of the charger start gate.
// Predicts each result from its own copy of the gate and ramp state and
// compares every result field with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module chg_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic        m_tuser,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [9:0]  cfg_data,
    output int          fail_count,
    output int          pending,
    output int          item_count,
    output int          result_count,
    output int          frame_count,
    output int          timeout_flagged
);
    timeunit 1ns;
    timeprecision 1ps;
    import chg_pkg::*;

    localparam int MAX_PRINTED = 40;

    // Register copy
    chg_mode_t   iface_mode;
    logic [9:0]  volt_target;
    logic [9:0]  reload_value;
    logic [7:0]  current_max;

    // Gate and ramp state copy
    logic [7:0]  duty_held;
    logic [9:0]  countdown;
    logic        timed_out_q;
    logic        permit;
    logic [7:0]  ramp;
    logic        charging_on;

    chg_result_t expected_results[$];

    // Print one mismatch line and count it
    task automatic report_mismatch(string what, logic [15:0] want, logic [15:0] got);
        if (fail_count < MAX_PRINTED)
            $display("%0t ns: %s mismatch on result %0d: expected 0x%0h, got 0x%0h",
                     $realtime, what, result_count, want, got);
        fail_count++;
    endtask

    // Apply one item to the state copy and form its result
    function automatic chg_result_t gate_and_ramp(chg_item_t it);
        chg_result_t res;
        int          next_ramp;
        res = '0;
        case (it.opcode)
            OP_START:
            begin
                case (iface_mode)
                    MODE_NONE:
                    begin
                        if (it.run_request && it.ac_request)
                            permit = !timed_out_q;
                        else
                        begin
                            // drop permission and restart the pilot countdown
                            timed_out_q = 1'b0;
                            countdown   = reload_value;
                            permit      = 1'b0;
                        end
                    end
                    MODE_DC:
                        permit = (duty_held != 8'd0) && it.run_request;
                    MODE_LIM, MODE_CPC, MODE_COMBO:
                        permit = it.run_request && it.ac_request;
                    default: ;
                endcase
            end
            OP_TICK:
            begin
                if (it.charge_mode_active)
                begin
                    // pilot countdown runs only while no duty is held
                    if (duty_held == 8'd0)
                    begin
                        if (countdown != 10'd0)
                            countdown = countdown - 10'd1;
                        else
                            timed_out_q = 1'b1;
                    end
                    else
                    begin
                        countdown   = reload_value;
                        timed_out_q = 1'b0;
                    end
                    res.pull_in_evse     = permit;
                    res.frame_valid      = 1'b1;
                    res.setpoint_word    = 16'(int'(volt_target) * int'(VOLT_SCALE));
                    res.current_setpoint = ramp;
                    // step towards the target, clamp to the limit, floor at zero
                    if (permit)
                    begin
                        next_ramp = int'(ramp);
                        if (it.measured_volts < volt_target)
                            next_ramp++;
                        else if (next_ramp > 0)
                            next_ramp--;
                        if (next_ramp >= int'(current_max))
                            next_ramp = int'(current_max);
                        ramp        = 8'(next_ramp);
                        charging_on = 1'b1;
                    end
                    else
                        ramp = 8'd0;
                end
                else
                    charging_on = 1'b0;
            end
            OP_DUTY:
                duty_held = it.pilot_duty;
            default: ;
        endcase
        res.clear_to_start = permit;
        res.charging       = charging_on;
        res.pilot_timeout  = timed_out_q;
        return res;
    endfunction

    // Compare one received result with the oldest prediction
    task automatic check_result(chg_result_t got);
        chg_result_t want;
        if (expected_results.size() == 0)
        begin
            report_mismatch("result with nothing expected", 16'd0, 16'd0);
            return;
        end
        want = expected_results.pop_front();
        if (got.clear_to_start !== want.clear_to_start)
            report_mismatch("clear_to_start", 16'(want.clear_to_start),
                            16'(got.clear_to_start));
        if (got.pull_in_evse !== want.pull_in_evse)
            report_mismatch("pull_in_evse", 16'(want.pull_in_evse),
                            16'(got.pull_in_evse));
        if (got.frame_valid !== want.frame_valid)
            report_mismatch("frame_valid", 16'(want.frame_valid),
                            16'(got.frame_valid));
        if (got.setpoint_word !== want.setpoint_word)
            report_mismatch("setpoint_word", want.setpoint_word, got.setpoint_word);
        if (got.current_setpoint !== want.current_setpoint)
            report_mismatch("current_setpoint", 16'(want.current_setpoint),
                            16'(got.current_setpoint));
        if (got.charging !== want.charging)
            report_mismatch("charging", 16'(want.charging), 16'(got.charging));
        if (got.pilot_timeout !== want.pilot_timeout)
            report_mismatch("pilot_timeout", 16'(want.pilot_timeout),
                            16'(got.pilot_timeout));
        if (got.frame_valid === 1'b1)
            frame_count++;
        if (got.pilot_timeout === 1'b1)
            timeout_flagged++;
    endtask

    // Unpack the channels and track the state on every handshake
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iface_mode   = MODE_NONE;
            volt_target  = 10'd0;
            reload_value = TIMEOUT_RESET;
            current_max  = MAX_CURRENT_RESET;
            duty_held    = 8'd0;
            countdown    = TIMEOUT_RESET;
            timed_out_q  = 1'b0;
            permit       = 1'b0;
            ramp         = 8'd0;
            charging_on  = 1'b0;
            expected_results.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (chg_reg_t'(cfg_index))
                    REG_INTERFACE_MODE: iface_mode   = chg_mode_t'(cfg_data[2:0]);
                    REG_VOLTAGE_TARGET: volt_target  = cfg_data;
                    REG_TIMEOUT_RELOAD: reload_value = cfg_data;
                    REG_MAX_CURRENT:    current_max  = cfg_data[7:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                expected_results.push_back(gate_and_ramp('{
                    opcode:             chg_op_t'(s_tuser),
                    run_request:        s_tdata[0],
                    ac_request:         s_tdata[1],
                    charge_mode_active: s_tdata[2],
                    measured_volts:     s_tdata[12:3],
                    pilot_duty:         s_tdata[20:13]}));
                item_count++;
            end
            if (m_tvalid && m_tready)
            begin
                check_result('{
                    clear_to_start:   m_tdata[0],
                    pull_in_evse:     m_tdata[1],
                    frame_valid:      m_tuser,
                    setpoint_word:    m_tdata[17:2],
                    current_setpoint: m_tdata[25:18],
                    charging:         m_tdata[26],
                    pilot_timeout:    m_tdata[27]});
                result_count++;
            end
            pending <= expected_results.size();
        end
    end

    initial
    begin
        fail_count      = 0;
        item_count      = 0;
        result_count    = 0;
        frame_count     = 0;
        timeout_flagged = 0;
    end

endmodule

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the charger start gate and current ramp.
// A directed opening walks start modes none and dc, the pilot countdown and the ramp
// limits; random phases then sweep every interface mode and register extreme
// with random gaps on both channels, while chg_checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import chg_pkg::*;

    localparam int CLK_PERIOD     = 4;
    localparam int RESET_CYCLES   = 7;
    localparam int RANDOM_PHASES  = 13;
    localparam int PHASE_ITEMS    = 125;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 2000;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;   // run_request, ac_request, charge_mode_active,
                                   // measured_volts[9:0], pilot_duty[7:0], zero pad
    logic [1:0]  s_tuser   = '0;   // opcode[1:0]
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;          // clear_to_start, pull_in_evse, setpoint_word[15:0],
                                   // current_setpoint[7:0], charging, pilot_timeout, zero pad
    logic        m_tuser;          // frame_valid
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [9:0]  cfg_data  = '0;

    int          fail_count;
    int          pending;
    int          item_count;
    int          result_count;
    int          frame_count;
    int          timeout_flagged;
    int          settings_used = 0;
    bit          idle_tx       = 1'b1;
    bit          idle_rx       = 1'b1;
    int          rx_hold       = 0;
    int          rx_draw       = 0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    charger_start_gate_and_current_ramp u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    chg_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .pending         (pending),
        .item_count      (item_count),
        .result_count    (result_count),
        .frame_count     (frame_count),
        .timeout_flagged (timeout_flagged)
    );

    // Result side: draw a stall length after every accepted result while idle_rx is set
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_hold  <= 0;
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (idle_rx)
                begin
                    rx_draw = $urandom_range(0, 5);
                    rx_hold  <= (rx_draw > 0) ? rx_draw - 1 : 0;
                    m_tready <= (rx_draw == 0);
                end
                else
                    m_tready <= 1'b1;
            end
            else if (rx_hold > 0)
            begin
                rx_hold  <= rx_hold - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Offer one item after a random gap while idle_tx is set, and hold it until taken
    task automatic send_item(chg_op_t op, logic run, logic ac, logic chg,
                             logic [9:0] volts, logic [7:0] duty);
        int gap;
        gap = idle_tx ? $urandom_range(0, 5) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {3'b000, duty, volts, chg, ac, run};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Random item, mostly well-formed gate and ramp traffic
    task automatic send_random_item(logic [9:0] target);
        int         pick;
        chg_op_t    op;
        logic [9:0] volts;
        logic [7:0] duty;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            op = OP_TICK;
        else if (pick < 70)
            op = OP_START;
        else if (pick < 92)
            op = OP_DUTY;
        else
            op = OP_NONE;
        // keep the measured voltage near the target now and then
        case ($urandom_range(0, 3))
            0: volts = target;
            1: volts = (target == 10'd0) ? 10'd0 : target - 10'd1;
            default: volts = 10'($urandom);
        endcase
        duty = ($urandom_range(0, 9) < 6) ? 8'd0 : 8'($urandom);
        send_item(op, $urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0,
                  $urandom_range(0, 7) != 0, volts, duty);
    endtask

    // Stop offering items and wait until every result is back
    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(chg_reg_t idx, logic [9:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    // Write all four registers while the block is idle
    task automatic configure(chg_mode_t mode, logic [9:0] target,
                             logic [9:0] reload, logic [7:0] limit);
        write_register(REG_INTERFACE_MODE, 10'(mode));
        write_register(REG_VOLTAGE_TARGET, target);
        write_register(REG_TIMEOUT_RELOAD, reload);
        write_register(REG_MAX_CURRENT, 10'(limit));
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Main sequence
    initial
    begin
        int         phase;
        int         k;
        logic [9:0] target;
        logic [9:0] reload;
        logic [7:0] limit;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Unused opcode at reset values, then mode none with a short countdown
        send_item(OP_NONE, 1'b1, 1'b1, 1'b1, 10'h3FF, 8'hFF);
        drain();
        configure(MODE_NONE, 10'd1023, 10'd2, 8'd255);
        send_item(OP_DUTY, 1'b0, 1'b0, 1'b0, 10'd0, 8'd0);
        send_item(OP_START, 1'b1, 1'b1, 1'b0, 10'd0, 8'd0);
        send_item(OP_TICK, 1'b0, 1'b0, 1'b1, 10'd0, 8'd0);
        send_item(OP_TICK, 1'b0, 1'b0, 1'b1, 10'd1023, 8'd0);
        send_item(OP_TICK, 1'b0, 1'b0, 1'b1, 10'd1023, 8'd0);
        send_item(OP_TICK, 1'b1, 1'b1, 1'b0, 10'd0, 8'd0);
        send_item(OP_TICK, 1'b0, 1'b0, 1'b1, 10'd0, 8'd0);
        send_item(OP_START, 1'b1, 1'b1, 1'b0, 10'd0, 8'd0);
        send_item(OP_START, 1'b0, 1'b1, 1'b0, 10'd0, 8'd0);
        send_item(OP_DUTY, 1'b0, 1'b0, 1'b0, 10'd0, 8'hFF);
        send_item(OP_TICK, 1'b0, 1'b0, 1'b1, 10'd512, 8'd0);
        send_item(OP_START, 1'b1, 1'b1, 1'b0, 10'd0, 8'd0);
        drain();

        // Mode dc fast with a zero current limit: ramp pinned at zero
        configure(MODE_DC, 10'd0, 10'd1023, 8'd0);
        send_item(OP_DUTY, 1'b0, 1'b0, 1'b0, 10'd0, 8'd0);
        send_item(OP_START, 1'b1, 1'b0, 1'b0, 10'd0, 8'd0);
        send_item(OP_DUTY, 1'b0, 1'b0, 1'b0, 10'd0, 8'hAA);
        send_item(OP_START, 1'b1, 1'b0, 1'b0, 10'd0, 8'd0);
        send_item(OP_TICK, 1'b0, 1'b0, 1'b1, 10'd0, 8'd0);
        send_item(OP_TICK, 1'b0, 1'b0, 1'b1, 10'd1023, 8'd0);
        send_item(OP_START, 1'b0, 1'b1, 1'b0, 10'd0, 8'd0);
        drain();

        // Random phases over all interface modes; gaps on and off
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case ($urandom_range(0, 2))
                0: target = 10'd0;
                1: target = 10'd1023;
                default: target = 10'($urandom);
            endcase
            reload = ($urandom_range(0, 4) == 0) ? 10'($urandom) : 10'($urandom_range(0, 12));
            case ($urandom_range(0, 3))
                0: limit = 8'd0;
                1: limit = 8'd255;
                default: limit = 8'($urandom);
            endcase
            if (phase == 0)
            begin
                reload = 10'd0;
                limit  = 8'd255;
            end
            idle_tx = (phase % 3) != 1;
            idle_rx = (phase % 4) != 2;
            configure(chg_mode_t'(phase % 8), target, reload, limit);
            for (k = 0; k < PHASE_ITEMS; k++)
                send_random_item(target);
            drain();
        end

        $display("Run covered %0d items and %0d results over %0d register settings,",
                 item_count, result_count, settings_used);
        $display("with %0d setpoint frames and %0d results flagging a pilot timeout.",
                 frame_count, timeout_flagged);
        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // End the run when no channel has moved for too long
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Watchdog expired after %0d quiet cycles, %0d results outstanding",
                 WATCHDOG_LIMIT, pending);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
